/* rtl/core/bresenham_step_pulse_generator_assert.svh */
// assertion macros for the step generator
`ifndef BRESENHAM_STEP_PULSE_GENERATOR_ASSERT_SVH
`define BRESENHAM_STEP_PULSE_GENERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BSPG_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("lbl failed");
`define BSPG_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("lbl failed");
`else
`define BSPG_ASSERT_IMP(lbl, a, c)
`define BSPG_ASSERT_NXT(lbl, a, c)
`endif
`endif

/* rtl/core/bspg_pkg.sv */
package bspg_pkg;
  localparam int QueueDepth = 16;
  localparam int QPtrW = $clog2(QueueDepth);
  localparam int QCntW = $clog2(QueueDepth + 1);
  localparam int StepW = 24;
  localparam int IvlW = 20;
  localparam int PwrW = 16;
  localparam int PosW = 32;
  localparam int DivW = StepW + StepW; // mag*idx fits here
  localparam int BlkW = 5 * StepW + 4 + 2 * IvlW + 2 * PwrW;

  typedef enum logic [1:0] {
    FN_ENQ   = 2'd0,
    FN_START = 2'd1,
    FN_TICK  = 2'd2,
    FN_STOP  = 2'd3
  } func_t;

  typedef struct packed {
    logic [StepW-1:0] steps_x;
    logic [StepW-1:0] y1_steps;
    logic [StepW-1:0] y2_steps;
    logic [StepW-1:0] steps_z;
    logic [StepW-1:0] total;
    logic [3:0]       dirs;
    logic [IvlW-1:0]  ivl_start;
    logic [IvlW-1:0]  ivl_end;
    logic [PwrW-1:0]  pwr_start;
    logic [PwrW-1:0]  pwr_end;
  } block_t;

  // command from front to back
  typedef struct packed {
    func_t func;
    logic  accepted;
    logic  q_empty;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_DIV, ST_OUT
  } state_t;
endpackage

/* rtl/core/bspg_ram.sv */
module bspg_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/bspg_front.sv */
// accepts items, owns the block queue pointers
module bspg_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     acc,
  input  bspg_pkg::func_t          func,
  input  logic                     pop,
  output logic                     we,
  output logic [bspg_pkg::QPtrW-1:0] waddr,
  output logic [bspg_pkg::QPtrW-1:0] raddr,
  output bspg_pkg::cmd_t           cmd,
  output logic [bspg_pkg::QCntW-1:0] count
);
  logic [bspg_pkg::QPtrW-1:0] head_r, tail_r;
  logic [bspg_pkg::QCntW-1:0] cnt_r;
  logic                       full;

  assign full  = (cnt_r == bspg_pkg::QCntW'(bspg_pkg::QueueDepth));
  assign we    = acc && (func == bspg_pkg::FN_ENQ) && !full;
  assign waddr = tail_r;
  assign raddr = head_r;
  assign count = cnt_r;

  always_comb begin
    cmd.func     = func;
    cmd.accepted = we;
    cmd.q_empty  = (cnt_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (we) tail_r <= (tail_r == bspg_pkg::QPtrW'(bspg_pkg::QueueDepth - 1)) ?
                        '0 : tail_r + 1'b1;
      if (pop) head_r <= (head_r == bspg_pkg::QPtrW'(bspg_pkg::QueueDepth - 1)) ?
                         '0 : head_r + 1'b1;
      cnt_r <= cnt_r + bspg_pkg::QCntW'(we) - bspg_pkg::QCntW'(pop);
    end
  end
endmodule

/* rtl/core/bspg_div.sv */
// restoring divider, one quotient bit per cycle
module bspg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [bspg_pkg::DivW-1:0]  num,
  input  logic [bspg_pkg::StepW-1:0] den,
  output logic                       done,
  output logic [bspg_pkg::DivW-1:0]  quo
);
  localparam int CntW = $clog2(bspg_pkg::DivW + 1);
  logic [bspg_pkg::DivW-1:0]  q_r;
  logic [bspg_pkg::StepW:0]   rem_r;
  logic [bspg_pkg::StepW:0]   sh;
  logic [CntW-1:0]            cnt_r;
  logic                       run_r;

  assign sh   = {rem_r[bspg_pkg::StepW-1:0], q_r[bspg_pkg::DivW-1]};
  assign done = run_r && (cnt_r == '0);
  assign quo  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (go) begin
      run_r <= 1'b1;
      cnt_r <= CntW'(bspg_pkg::DivW);
    end else if (done) begin
      run_r <= 1'b0;
    end else if (run_r) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r   <= num;
      rem_r <= '0;
    end else if (run_r && cnt_r != '0) begin
      if (sh >= {1'b0, den}) begin
        rem_r <= sh - {1'b0, den};
        q_r   <= {q_r[bspg_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_r <= sh;
        q_r   <= {q_r[bspg_pkg::DivW-2:0], 1'b0};
      end
    end
  end
endmodule

/* rtl/core/bspg_back.sv */
// executes commands: Bresenham tick, block load, stop, interpolation
module bspg_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_vld,
  input  bspg_pkg::cmd_t              cmd,
  input  bspg_pkg::block_t            head_blk,
  input  logic [bspg_pkg::IvlW-1:0]   min_ivl,
  input  logic [bspg_pkg::QCntW-1:0]  q_count,
  output logic                        pop,
  output logic                        idle,
  output logic                        res_vld,
  output logic [3:0]                  res_pulses,
  output logic [3:0]                  res_dirs,
  output logic [bspg_pkg::PwrW-1:0]   res_power,
  output logic [bspg_pkg::IvlW-1:0]   res_ivl,
  output logic                        res_running,
  output logic                        res_busy,
  output logic                        res_acc,
  output logic [bspg_pkg::PosW-1:0]   res_px,
  output logic [bspg_pkg::PosW-1:0]   res_py,
  output logic [bspg_pkg::PosW-1:0]   res_pz
);
  localparam int SW = bspg_pkg::StepW;
  localparam int DW = bspg_pkg::DivW;

  bspg_pkg::state_t st_r, st_nxt;
  bspg_pkg::block_t act_r;
  logic [SW:0]   accum_r [4];
  logic [SW-1:0] idx_r;
  logic [bspg_pkg::PosW-1:0] pos_r [3];
  logic [bspg_pkg::PwrW-1:0] pwr_r;
  logic [bspg_pkg::IvlW-1:0] ivl_r;
  logic          run_r, acc_r, sel_r;
  logic [3:0]    pulse_r;
  logic [SW-1:0] tot;
  logic [DW-1:0] prod_c;
  logic [bspg_pkg::IvlW-1:0] mag, a_v, b_v;
  logic          up;
  logic          dgo, ddone;
  logic [DW-1:0] dquo;
  logic [bspg_pkg::IvlW:0]   ires;
  logic [3:0]    pulse_c;
  logic [SW+1:0] sum_c [4];
  logic [SW:0]   nacc_c [4];
  logic          fin_c;

  assign tot = (act_r.total == '0) ? SW'(1) : act_r.total;

  // accumulator plus steps can exceed 2^(SW+1), so the sum carries one more bit
  always_comb begin
    logic [SW-1:0] stp [4];
    logic [SW+1:0] dif;
    stp[0] = act_r.steps_x;
    stp[1] = act_r.y1_steps;
    stp[2] = act_r.y2_steps;
    stp[3] = act_r.steps_z;
    for (int a = 0; a < 4; a++) begin
      sum_c[a] = {1'b0, accum_r[a]} + {2'b00, stp[a]};
      pulse_c[a] = (sum_c[a] >= {2'b00, tot});
      dif = sum_c[a] - {2'b00, tot};
      nacc_c[a] = pulse_c[a] ? dif[SW:0] : sum_c[a][SW:0];
    end
  end
  assign fin_c = ((idx_r + 1'b1) >= act_r.total);

  // sel_r: 0 interval pass, 1 power pass
  always_comb begin
    if (!sel_r) begin
      a_v = act_r.ivl_start;
      b_v = act_r.ivl_end;
    end else begin
      a_v = bspg_pkg::IvlW'(act_r.pwr_start);
      b_v = bspg_pkg::IvlW'(act_r.pwr_end);
    end
    up  = (b_v >= a_v);
    mag = up ? b_v - a_v : a_v - b_v;
  end

  assign prod_c = DW'(mag) * DW'(idx_r);

  bspg_div u_div (
    .clk (clk), .rst_n (rst_n), .go (dgo), .num (prod_c), .den (tot),
    .done (ddone), .quo (dquo)
  );

  // quotient <= mag, so low bits suffice
  assign ires = up ? {1'b0, a_v} + {1'b0, dquo[bspg_pkg::IvlW-1:0]}
                   : {1'b0, a_v} - {1'b0, dquo[bspg_pkg::IvlW-1:0]};

  always_comb begin
    st_nxt = st_r;
    dgo    = 1'b0;
    pop    = 1'b0;
    case (st_r)
      bspg_pkg::ST_IDLE: begin
        if (cmd_vld) begin
          case (cmd.func)
            bspg_pkg::FN_START: begin
              if (!run_r && !cmd.q_empty) begin
                pop = 1'b1;
                st_nxt = bspg_pkg::ST_LOAD;
              end else st_nxt = bspg_pkg::ST_OUT;
            end
            bspg_pkg::FN_TICK: begin
              if (run_r && fin_c) begin
                if (q_count != '0) begin
                  pop = 1'b1;
                  st_nxt = bspg_pkg::ST_LOAD;
                end else st_nxt = bspg_pkg::ST_OUT;
              end else if (run_r) st_nxt = bspg_pkg::ST_MUL;
              else st_nxt = bspg_pkg::ST_OUT;
            end
            default: st_nxt = bspg_pkg::ST_OUT;
          endcase
        end
      end
      bspg_pkg::ST_LOAD: st_nxt = bspg_pkg::ST_OUT;
      bspg_pkg::ST_MUL: begin
        dgo = 1'b1;
        st_nxt = bspg_pkg::ST_DIV;
      end
      bspg_pkg::ST_DIV: begin
        if (ddone) st_nxt = sel_r ? bspg_pkg::ST_OUT : bspg_pkg::ST_MUL;
      end
      bspg_pkg::ST_OUT: st_nxt = bspg_pkg::ST_IDLE;
      default: st_nxt = bspg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= bspg_pkg::ST_IDLE;
    else st_r <= st_nxt;
  end

  // head read data is valid in the cycle after pop is issued (ST_LOAD)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      for (int a = 0; a < 4; a++) accum_r[a] <= '0;
      for (int p = 0; p < 3; p++) pos_r[p] <= '0;
      idx_r <= '0;
      pwr_r <= '0;
      ivl_r <= '0;
      run_r <= 1'b0;
      acc_r <= 1'b0;
      sel_r <= 1'b0;
      pulse_r <= '0;
    end else begin
      case (st_r)
        bspg_pkg::ST_IDLE: begin
          if (cmd_vld) begin
            acc_r   <= cmd.accepted;
            pulse_r <= '0;
            sel_r   <= 1'b0;
            if (cmd.func == bspg_pkg::FN_STOP) begin
              run_r <= 1'b0;
              pwr_r <= '0;
            end else if (cmd.func == bspg_pkg::FN_TICK && run_r) begin
              pulse_r <= pulse_c;
              for (int a = 0; a < 4; a++) accum_r[a] <= nacc_c[a];
              if (pulse_c[0]) pos_r[0] <= act_r.dirs[0] ? pos_r[0] + 1'b1 : pos_r[0] - 1'b1;
              if (pulse_c[1]) pos_r[1] <= act_r.dirs[1] ? pos_r[1] + 1'b1 : pos_r[1] - 1'b1;
              if (pulse_c[3]) pos_r[2] <= act_r.dirs[3] ? pos_r[2] + 1'b1 : pos_r[2] - 1'b1;
              idx_r <= idx_r + 1'b1;
              if (fin_c && q_count == '0) begin
                run_r <= 1'b0;
                pwr_r <= '0;
              end
            end
          end
        end
        bspg_pkg::ST_LOAD: begin
          act_r <= head_blk;
          run_r <= 1'b1;
          idx_r <= '0;
          for (int a = 0; a < 4; a++) accum_r[a] <= '0;
          pwr_r <= head_blk.pwr_start;
          ivl_r <= (head_blk.ivl_start < min_ivl) ? min_ivl : head_blk.ivl_start;
        end
        bspg_pkg::ST_DIV: begin
          if (ddone) begin
            sel_r <= 1'b1;
            if (!sel_r)
              ivl_r <= (ires[bspg_pkg::IvlW-1:0] < min_ivl) ? min_ivl
                       : ires[bspg_pkg::IvlW-1:0];
            else pwr_r <= ires[bspg_pkg::PwrW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign idle        = (st_r == bspg_pkg::ST_IDLE);
  assign res_vld     = (st_r == bspg_pkg::ST_OUT);
  assign res_pulses  = pulse_r;
  assign res_dirs    = act_r.dirs;
  assign res_power   = pwr_r;
  assign res_ivl     = ivl_r;
  assign res_running = run_r;
  assign res_busy    = run_r || (q_count != '0);
  assign res_acc     = acc_r;
  assign res_px      = pos_r[0];
  assign res_py      = pos_r[1];
  assign res_pz      = pos_r[2];
endmodule

/* rtl/core/bresenham_step_pulse_generator.sv */
// Channel  | Handshake              | Payload
// in       | start & !busy          | in_func, in_block_*
// out      | out_valid (1 cycle)    | out_step_pulses .. out_position_z
// cfg      | APB psel/penable/pwrite | reg 0 min_step_interval at 0x0
// Enqueue, stop, non-loading start, idle tick, end tick with empty queue: ST_OUT only.
// A start or block-ending tick that loads the next block: RAM read, ST_LOAD, ST_OUT.
// Other ticks: two 48-step serial divisions (interval, power), then ST_OUT.
// busy stays high from accept through the result cycle; one item in flight.
// Reset: synchronous, active low; queue empty, min_step_interval = 10.
// Results cannot be stalled by the receiver.
module bresenham_step_pulse_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [23:0] in_block_steps_x,
  input  logic [23:0] in_block_steps_y1,
  input  logic [23:0] in_block_steps_y2,
  input  logic [23:0] in_block_steps_z,
  input  logic [23:0] in_block_total,
  input  logic [3:0]  in_block_directions,
  input  logic [19:0] in_block_start_interval,
  input  logic [19:0] in_block_end_interval,
  input  logic [15:0] in_block_power_start,
  input  logic [15:0] in_block_power_end,
  output logic        out_valid,
  output logic [3:0]  out_step_pulses,
  output logic [3:0]  out_direction_lines,
  output logic [15:0] out_laser_power,
  output logic [19:0] out_next_step_interval,
  output logic        out_running,
  output logic        out_busy_res,
  output logic        out_enqueue_accepted,
  output logic signed [31:0] out_position_x,
  output logic signed [31:0] out_position_y,
  output logic signed [31:0] out_position_z,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  `include "bresenham_step_pulse_generator_assert.svh"

  logic acc, we, pop, idle, cmd_vld_r;
  logic [bspg_pkg::QPtrW-1:0] waddr, raddr;
  logic [bspg_pkg::QCntW-1:0] q_count;
  bspg_pkg::cmd_t cmd, cmd_r;
  bspg_pkg::block_t wblk, rblk;
  logic [bspg_pkg::IvlW-1:0] min_ivl_r;
  logic [31:0] pos_x, pos_y, pos_z;

  assign pready = 1'b1;
  assign prdata = {12'd0, min_ivl_r};
  always_ff @(posedge clk) begin
    if (!rst_n) min_ivl_r <= bspg_pkg::IvlW'(10);
    else if (psel && penable && pwrite && !paddr) min_ivl_r <= pwdata[bspg_pkg::IvlW-1:0];
  end

  assign busy = cmd_vld_r || !idle;
  assign acc  = start && !busy;

  assign wblk = '{steps_x: in_block_steps_x, y1_steps: in_block_steps_y1,
                  y2_steps: in_block_steps_y2, steps_z: in_block_steps_z,
                  total: in_block_total, dirs: in_block_directions,
                  ivl_start: in_block_start_interval, ivl_end: in_block_end_interval,
                  pwr_start: in_block_power_start, pwr_end: in_block_power_end};

  bspg_front u_front (
    .clk (clk), .rst_n (rst_n), .acc (acc), .func (bspg_pkg::func_t'(in_func)),
    .pop (pop), .we (we), .waddr (waddr), .raddr (raddr), .cmd (cmd),
    .count (q_count)
  );

  bspg_ram #(.Width(bspg_pkg::BlkW), .Depth(bspg_pkg::QueueDepth)) u_ram (
    .clk (clk), .we (we), .waddr (waddr), .wdata (wblk), .raddr (raddr), .rdata (rblk)
  );

  // one-entry command queue between front and back
  always_ff @(posedge clk) begin
    if (!rst_n) cmd_vld_r <= 1'b0;
    else if (acc) cmd_vld_r <= 1'b1;
    else if (idle) cmd_vld_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (acc) cmd_r <= cmd;
  end

  bspg_back u_back (
    .clk (clk), .rst_n (rst_n), .cmd_vld (cmd_vld_r && idle), .cmd (cmd_r),
    .head_blk (rblk), .min_ivl (min_ivl_r), .q_count (q_count), .pop (pop),
    .idle (idle), .res_vld (out_valid), .res_pulses (out_step_pulses),
    .res_dirs (out_direction_lines), .res_power (out_laser_power),
    .res_ivl (out_next_step_interval), .res_running (out_running),
    .res_busy (out_busy_res), .res_acc (out_enqueue_accepted),
    .res_px (pos_x), .res_py (pos_y), .res_pz (pos_z)
  );
  assign out_position_x = pos_x;
  assign out_position_y = pos_y;
  assign out_position_z = pos_z;

  `BSPG_ASSERT_IMP(a_no_pulse_enq, out_valid && out_enqueue_accepted, out_step_pulses == 4'd0)
  `BSPG_ASSERT_NXT(a_acc_busy, acc, busy)
  `BSPG_ASSERT_IMP(a_qcount_bound, 1'b1, q_count <= bspg_pkg::QCntW'(bspg_pkg::QueueDepth))
  `BSPG_ASSERT_IMP(a_stop_power, out_valid && !out_running, out_laser_power == 16'd0)
endmodule
